[rtl/core/sbfd_pkg.sv]
// sbfd_pkg: shared constants, codes and types of the SBUS frame decoder.
// No dependencies; used by every module under rtl/core.
`timescale 1ns / 1ps
`default_nettype none

package sbfd_pkg;

   localparam int NumChannels  = 16;
   localparam int ChanWidth    = 11;
   localparam int LevelWidth   = 4;
   localparam int PayloadDepth = 23;   // frame bytes 1..23
   localparam int ChanBytes    = 22;   // frame bytes 1..22 carry the channels
   localparam int FlagEntry    = 22;   // payload entry of frame byte 23
   localparam int PosWidth     = 5;
   localparam int IdxWidth     = $clog2(NumChannels);
   localparam int PtrWidth     = $clog2(PayloadDepth);

   localparam logic [PosWidth-1:0]   LastPos        = PosWidth'(24);
   localparam logic [7:0]            HeaderByte     = 8'h0F;
   localparam logic [7:0]            EndByte        = 8'h00;
   localparam logic [7:0]            FlagFailsafe   = 8'h04;
   localparam logic [7:0]            FlagFrameLost  = 8'h08;
   localparam logic [LevelWidth-1:0] ThresholdReset = LevelWidth'(10);

   // request command codes
   localparam logic CmdByte     = 1'b0;
   localparam logic CmdLinkLost = 1'b1;

   typedef logic [ChanWidth-1:0] chan_type;

   // what one accepted request does to the link state
   typedef struct packed {
      logic frame_ok;    // byte 24 closed a valid frame
      logic failsafe;    // failsafe or frame-lost flag of that frame
      logic link_lost;   // link-lost command
   } frame_event_type;

   // link state after the request
   typedef struct packed {
      logic                  connected;
      logic [LevelWidth-1:0] level;
      logic                  clear;     // frame triggered disconnect, zero channels
   } link_status_type;

endpackage : sbfd_pkg

`default_nettype wire

[rtl/core/sbfd_frame_parser.sv]
// sbfd_frame_parser: byte position tracking, payload capture and channel unpack.
// Depends on sbfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbfd_frame_parser (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic                     cmd,
   input  wire logic [7:0]               data_byte,
   input  wire logic                     frame_start,
   output logic                          close_byte,
   output sbfd_pkg::frame_event_type     event_out,
   output sbfd_pkg::chan_type            chans [sbfd_pkg::NumChannels]
);

   logic [sbfd_pkg::PosWidth-1:0] pos_ff, pos_in;
   logic                          open_ff, open_in;
   logic                          header_ok_ff, header_ok_in;
   logic [7:0]                    payload_ff [sbfd_pkg::PayloadDepth];
   logic                          wr_en;
   logic [sbfd_pkg::PtrWidth-1:0] wr_ptr;
   logic [8*sbfd_pkg::ChanBytes-1:0] bits;

   // byte 24 of an open frame
   assign close_byte = (cmd == sbfd_pkg::CmdByte) && !frame_start && open_ff
                       && (pos_ff == sbfd_pkg::LastPos);

   assign wr_ptr = sbfd_pkg::PtrWidth'(pos_ff - sbfd_pkg::PosWidth'(1));
   assign wr_en  = accept && (cmd == sbfd_pkg::CmdByte) && !frame_start && open_ff
                   && (pos_ff != sbfd_pkg::LastPos);

   always_comb begin
      pos_in       = pos_ff;
      open_in      = open_ff;
      header_ok_in = header_ok_ff;
      event_out    = '0;
      if (accept) begin
         priority if (cmd == sbfd_pkg::CmdLinkLost) begin
            pos_in              = '0;
            open_in             = 1'b0;
            header_ok_in        = 1'b0;
            event_out.link_lost = 1'b1;
         end else if (frame_start) begin
            pos_in       = sbfd_pkg::PosWidth'(1);
            open_in      = 1'b1;
            header_ok_in = (data_byte == sbfd_pkg::HeaderByte);
         end else if (!open_ff) begin
            // stray byte, no frame open
         end else if (pos_ff != sbfd_pkg::LastPos) begin
            pos_in = pos_ff + sbfd_pkg::PosWidth'(1);
         end else begin
            pos_in             = '0;
            open_in            = 1'b0;
            event_out.frame_ok = header_ok_ff && (data_byte == sbfd_pkg::EndByte);
            event_out.failsafe =
               |(payload_ff[sbfd_pkg::FlagEntry] &
                 (sbfd_pkg::FlagFailsafe | sbfd_pkg::FlagFrameLost));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         open_ff      <= 1'b0;
         header_ok_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         open_ff      <= open_in;
         header_ok_ff <= header_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         payload_ff[wr_ptr] <= data_byte;
      end
   end

   // little-endian bit stream of bytes 1..22, eleven bits per channel
   always_comb begin
      for (int i = 0; i < sbfd_pkg::ChanBytes; i++) begin
         bits[8*i +: 8] = payload_ff[i];
      end
      for (int k = 0; k < sbfd_pkg::NumChannels; k++) begin
         chans[k] = bits[sbfd_pkg::ChanWidth*k +: sbfd_pkg::ChanWidth];
      end
   end

endmodule : sbfd_frame_parser

`default_nettype wire

[rtl/core/sbfd_failsafe.sv]
// sbfd_failsafe: saturating failsafe debounce counter and connected flag.
// Depends on sbfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbfd_failsafe (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire sbfd_pkg::frame_event_type           event_in,
   input  wire logic [sbfd_pkg::LevelWidth-1:0]     threshold,
   output sbfd_pkg::link_status_type                status
);

   logic [sbfd_pkg::LevelWidth-1:0] level_ff, level_in, stepped;
   logic                            connected_ff, connected_in;
   logic                            clear;

   always_comb begin
      level_in     = level_ff;
      connected_in = connected_ff;
      clear        = 1'b0;
      stepped      = level_ff;
      priority if (event_in.link_lost) begin
         level_in     = '0;
         connected_in = 1'b0;
      end else if (event_in.frame_ok) begin
         if (event_in.failsafe) begin
            if (level_ff < threshold) begin
               stepped = level_ff + sbfd_pkg::LevelWidth'(1);
            end
            if ((stepped >= threshold) && connected_ff) begin
               connected_in = 1'b0;
               clear        = 1'b1;
            end
         end else begin
            if (level_ff != '0) begin
               stepped = level_ff - sbfd_pkg::LevelWidth'(1);
            end
            if ((stepped == '0) && !connected_ff) begin
               connected_in = 1'b1;
            end
         end
         level_in = stepped;
      end else begin
         // no change
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= '0;
         connected_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         connected_ff <= connected_in;
      end
   end

   assign status.connected = connected_in;
   assign status.level     = level_in;
   assign status.clear     = clear;

endmodule : sbfd_failsafe

`default_nettype wire

[rtl/core/sbfd_result_drain.sv]
// sbfd_result_drain: holds one frame's sixteen channel results and shifts them out.
// Depends on sbfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbfd_result_drain (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 load,
   input  wire sbfd_pkg::chan_type                   chans [sbfd_pkg::NumChannels],
   input  wire sbfd_pkg::link_status_type            status,
   input  wire logic                                 failsafe,
   output logic                                      free,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [sbfd_pkg::IdxWidth-1:0]             rsp_channel_index,
   output logic [sbfd_pkg::ChanWidth-1:0]            rsp_channel_value,
   output logic                                      rsp_tx_connected,
   output logic                                      rsp_frame_failsafe,
   output logic [sbfd_pkg::LevelWidth-1:0]           rsp_failsafe_level,
   output logic                                      rsp_last
);

   localparam logic [sbfd_pkg::IdxWidth-1:0] LastIdx =
      sbfd_pkg::IdxWidth'(sbfd_pkg::NumChannels - 1);

   logic                              busy_ff, busy_in;
   logic [sbfd_pkg::IdxWidth-1:0]     idx_ff, idx_in;
   sbfd_pkg::chan_type                chan_ff [sbfd_pkg::NumChannels];
   logic                              connected_ff;
   logic                              failsafe_ff;
   logic [sbfd_pkg::LevelWidth-1:0]   level_ff;
   logic                              take;

   assign take = busy_ff && rsp_ready;
   assign free = !busy_ff || (rsp_ready && (idx_ff == LastIdx));

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      priority if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (take) begin
         busy_in = (idx_ff != LastIdx);
         idx_in  = idx_ff + sbfd_pkg::IdxWidth'(1);
      end else begin
         // hold
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   // payload: loaded on a valid frame, shifted toward entry 0 per result
   always_ff @(posedge clock) begin
      if (load) begin
         for (int k = 0; k < sbfd_pkg::NumChannels; k++) begin
            chan_ff[k] <= status.clear ? '0 : chans[k];
         end
         connected_ff <= status.connected;
         failsafe_ff  <= failsafe;
         level_ff     <= status.level;
      end else if (take) begin
         for (int k = 0; k < sbfd_pkg::NumChannels - 1; k++) begin
            chan_ff[k] <= chan_ff[k+1];
         end
      end
   end

   assign rsp_valid          = busy_ff;
   assign rsp_channel_index  = idx_ff;
   assign rsp_channel_value  = chan_ff[0];
   assign rsp_tx_connected   = connected_ff;
   assign rsp_frame_failsafe = failsafe_ff;
   assign rsp_failsafe_level = level_ff;
   assign rsp_last           = (idx_ff == LastIdx);

endmodule : sbfd_result_drain

`default_nettype wire

[rtl/core/sbus_frame_decoder_failsafe.sv]
// sbus_frame_decoder_failsafe: top level of the SBUS frame decoder with failsafe debounce.
// Depends on sbfd_pkg, sbfd_frame_parser, sbfd_failsafe and sbfd_result_drain.
//
// Usage:
//  - req_*: one request per received byte (req_cmd = 0) or a link-lost event
//    (req_cmd = 1). req_frame_start marks byte 0 of a frame. One request can
//    be taken every cycle, but for the byte-24 stall described below.
//  - csr_*: writes lost_threshold (reset 10). Always ready; write only while idle.
//  - rsp_*: a valid 25-byte frame (0x0F header, 0x00 end byte) yields sixteen
//    responses, channel 0 to 15, with rsp_last on channel 15.
//  - Responses: the first response is valid in the cycle after byte 24 is accepted;
//    the following ones drain at one per cycle while rsp_ready is high.
//  - Throughput: one request per cycle. The only stall is byte 24 of a frame
//    while the previous frame's sixteen responses are still held in the
//    result register; it is taken in the cycle the last one leaves. A new
//    frame's bytes 0..23 and link-lost events are taken meanwhile.
//  - Reset (synchronous): no frame open, counter 0, disconnected, threshold 10,
//    no responses pending.
//  - A stalled receiver only holds the current response; results are never
//    dropped or reordered.
`timescale 1ns / 1ps
`default_nettype none

module sbus_frame_decoder_failsafe (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // byte / event requests
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_cmd,
   input  wire logic [7:0]                          req_data_byte,
   input  wire logic                                req_frame_start,
   // threshold register
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [sbfd_pkg::LevelWidth-1:0]     csr_lost_threshold,
   // channel responses
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [sbfd_pkg::IdxWidth-1:0]            rsp_channel_index,
   output logic [sbfd_pkg::ChanWidth-1:0]           rsp_channel_value,
   output logic                                     rsp_tx_connected,
   output logic                                     rsp_frame_failsafe,
   output logic [sbfd_pkg::LevelWidth-1:0]          rsp_failsafe_level,
   output logic                                     rsp_last
);

   logic                              accept;
   logic                              close_byte;
   logic                              drain_free;
   sbfd_pkg::frame_event_type         frame_event;
   sbfd_pkg::link_status_type         status;
   sbfd_pkg::chan_type                chans [sbfd_pkg::NumChannels];
   logic [sbfd_pkg::LevelWidth-1:0]   threshold_ff;

   // config register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= sbfd_pkg::ThresholdReset;
      end else if (csr_valid && csr_ready) begin
         threshold_ff <= csr_lost_threshold;
      end
   end

   // closing byte waits until the result register can take a new frame
   assign req_ready = !close_byte || drain_free;
   assign accept    = req_valid && req_ready;

   sbfd_frame_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cmd         (req_cmd),
      .data_byte   (req_data_byte),
      .frame_start (req_frame_start),
      .close_byte  (close_byte),
      .event_out   (frame_event),
      .chans       (chans)
   );

   sbfd_failsafe u_failsafe (
      .clock     (clock),
      .reset     (reset),
      .event_in  (frame_event),
      .threshold (threshold_ff),
      .status    (status)
   );

   sbfd_result_drain u_drain (
      .clock              (clock),
      .reset              (reset),
      .load               (frame_event.frame_ok),
      .chans              (chans),
      .status             (status),
      .failsafe           (frame_event.failsafe),
      .free               (drain_free),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_channel_index  (rsp_channel_index),
      .rsp_channel_value  (rsp_channel_value),
      .rsp_tx_connected   (rsp_tx_connected),
      .rsp_frame_failsafe (rsp_frame_failsafe),
      .rsp_failsafe_level (rsp_failsafe_level),
      .rsp_last           (rsp_last)
   );

   // a clean frame that leaves the counter at zero is always connected
   a_clean_zero_connected : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_failsafe && (rsp_failsafe_level == '0))
      |-> rsp_tx_connected)
      else $error("clean frame at level zero reported disconnected");

   // responses of a frame come in channel order without gaps
   a_index_steps : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last)
      |=> (rsp_valid && (rsp_channel_index ==
           $past(rsp_channel_index) + sbfd_pkg::IdxWidth'(1))))
      else $error("response channel index skipped");

   // a link-lost event leaves the counter at zero and the link disconnected
   a_link_lost_clears : assert property (@(posedge clock) disable iff (reset)
      (accept && (req_cmd == sbfd_pkg::CmdLinkLost))
      |-> (!status.connected && (status.level == '0) && !frame_event.frame_ok))
      else $error("link-lost did not clear link state");

endmodule : sbus_frame_decoder_failsafe

`default_nettype wire
